[src/bilinear_resize_packed8_pkg.sv]
// Shared types and constants for the bilinear resize block.
package brp8_pkg;

    localparam int unsigned MAX_IN_WIDTH_D  = 64;
    localparam int unsigned MAX_IN_HEIGHT_D = 64;
    localparam int unsigned MAX_OUT_DIM_D   = 256;
    localparam int unsigned PLANES_D        = 4;
    localparam int unsigned LANES_D         = 8;

    // Configuration register indexes.
    localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ALIGN      = 3'd4;

    // Input item kinds.
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    // Field widths fixed by the item format.
    localparam int unsigned ROW_W   = 8;
    localparam int unsigned COL_W   = 8;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned LANE_W  = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DAT_W   = 9;
    localparam int unsigned FRAC_W  = 16;

    // Input item payload.
    typedef struct packed {
        logic                      kind;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic [PLANE_W-1:0]        plane;
        logic signed [LANE_W-1:0]  lane7;
        logic signed [LANE_W-1:0]  lane6;
        logic signed [LANE_W-1:0]  lane5;
        logic signed [LANE_W-1:0]  lane4;
        logic signed [LANE_W-1:0]  lane3;
        logic signed [LANE_W-1:0]  lane2;
        logic signed [LANE_W-1:0]  lane1;
        logic signed [LANE_W-1:0]  lane0;
    } t_in_item;

    // Result item payload.
    typedef struct packed {
        logic                      coord_error;
        logic signed [LANE_W-1:0]  out_lane7;
        logic signed [LANE_W-1:0]  out_lane6;
        logic signed [LANE_W-1:0]  out_lane5;
        logic signed [LANE_W-1:0]  out_lane4;
        logic signed [LANE_W-1:0]  out_lane3;
        logic signed [LANE_W-1:0]  out_lane2;
        logic signed [LANE_W-1:0]  out_lane1;
        logic signed [LANE_W-1:0]  out_lane0;
    } t_out_item;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;     // capture the accepted beat
        logic       wr_mem;   // write the captured pixel into the store
        logic       div_go;   // start both coordinate dividers
        logic       rd_go;    // issue the neighbour read for rd_sel
        logic [1:0] rd_sel;   // which neighbour: 0 p00, 1 p01, 2 p10, 3 p11
        logic       acc_go;   // accumulate the neighbour that has arrived
        logic [1:0] acc_sel;
        logic       finish;   // round and register the result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_write;
        logic wr_ok;
        logic coord_bad;
        logic div_done;
    } t_sts;

endpackage

[src/brp8_if.sv]
// Valid/ready channel interfaces for items and configuration writes.
interface brp8_item_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brp8_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/brp8_div.sv]
// Restoring divider, one quotient bit per cycle.
module brp8_div #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic          o_done
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [DW:0]   w_sh;

    // Shift one numerator bit into the remainder, subtract when it fits.
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_sh   = '0;
        if (i_go) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            w_sh = {r_rem[DW-1:0], r_quo[NW-1]};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_go) begin
            r_den <= i_den;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = !r_busy;
endmodule

[src/brp8_ctrl.sv]
// Controller state machine sequencing writes and bilinear computes.
module brp8_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output brp8_pkg::t_cmd o_cmd,
    input  brp8_pkg::t_sts i_sts
);
    import brp8_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DECO = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_oval, n_oval;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_oval  = r_oval;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        if (r_oval && i_out_ready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECO;
                end
            end
            S_DECO: begin
                if (i_sts.is_write) begin
                    o_cmd.wr_mem = i_sts.wr_ok;
                    n_state      = S_IDLE;
                end else if (i_sts.coord_bad) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_step  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // The neighbour read at one step is accumulated at the step after it.
                if (r_step < 3'd4) begin
                    o_cmd.rd_go  = 1'b1;
                    o_cmd.rd_sel = r_step[1:0];
                end
                if (r_step != 3'd0) begin
                    o_cmd.acc_go  = 1'b1;
                    o_cmd.acc_sel = 2'(r_step - 3'd1);
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd4) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_oval       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_oval  <= n_oval;
        end
    end

    assign o_out_valid = r_oval;
endmodule

[src/brp8_dp.sv]
// Datapath: configuration, coordinate mapping, image store and blending.
module brp8_dp #(
    parameter int unsigned MAX_IN_WIDTH  = brp8_pkg::MAX_IN_WIDTH_D,
    parameter int unsigned MAX_IN_HEIGHT = brp8_pkg::MAX_IN_HEIGHT_D,
    parameter int unsigned PLANES        = brp8_pkg::PLANES_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [8:0]          i_cfg_dat,
    input  brp8_pkg::t_in_item  i_item,
    input  brp8_pkg::t_cmd      i_cmd,
    output brp8_pkg::t_sts      o_sts,
    output brp8_pkg::t_out_item o_res
);
    import brp8_pkg::*;

    localparam int unsigned XW  = $clog2(MAX_IN_WIDTH);
    localparam int unsigned YW  = $clog2(MAX_IN_HEIGHT);
    localparam int unsigned PW  = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int unsigned AW  = PW + YW + XW;
    localparam int unsigned DEP = 2 ** AW;
    localparam int unsigned PXW = 8 * LANE_W;
    // Numerator of the mapping: up to (2*255+1)*127 << 16, plus margin.
    localparam int unsigned NW  = 7 + 10 + FRAC_W + 1;
    localparam int unsigned DNW = 11;

    // Configuration registers.
    logic [6:0] r_iw, r_ih;
    logic [8:0] r_ow, r_oh;
    logic       r_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw <= 7'd64;
            r_ih <= 7'd64;
            r_ow <= 9'd64;
            r_oh <= 9'd64;
            r_ac <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IN_WIDTH:   r_iw <= i_cfg_dat[6:0];
                REG_IN_HEIGHT:  r_ih <= i_cfg_dat[6:0];
                REG_OUT_WIDTH:  r_ow <= i_cfg_dat;
                REG_OUT_HEIGHT: r_oh <= i_cfg_dat;
                REG_ALIGN:      r_ac <= i_cfg_dat[0];
                default: ;
            endcase
        end
    end

    // Captured item.
    t_in_item r_it;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_it <= i_item;
        end
    end

    // Source sizes saturated to 1..MAX.
    logic [10:0] w_iw, w_ih;
    always_comb begin
        w_iw = {4'd0, r_iw};
        w_ih = {4'd0, r_ih};
        if (r_iw == 7'd0) w_iw = 11'd1;
        else if ({4'd0, r_iw} > 11'(MAX_IN_WIDTH)) w_iw = 11'(MAX_IN_WIDTH);
        if (r_ih == 7'd0) w_ih = 11'd1;
        else if ({4'd0, r_ih} > 11'(MAX_IN_HEIGHT)) w_ih = 11'(MAX_IN_HEIGHT);
    end

    // Status decode.
    assign o_sts.is_write  = (r_it.kind == KIND_WRITE);
    assign o_sts.wr_ok     = ({3'd0, r_it.row} < 11'(MAX_IN_HEIGHT))
                          && ({3'd0, r_it.col} < 11'(MAX_IN_WIDTH))
                          && ({5'd0, r_it.plane} < 7'(PLANES));
    assign o_sts.coord_bad = ({1'b0, r_it.row} >= r_oh) || ({1'b0, r_it.col} >= r_ow)
                          || ({5'd0, r_it.plane} >= 7'(PLANES));

    // Numerator and divisor per axis; registered before the dividers start.
    logic [NW-1:0]  r_ny, r_nx;
    logic [DNW-1:0] r_dy, r_dx;
    logic           r_zy, r_zx;

    function automatic logic [NW+DNW:0] map_nd(input logic [10:0] insz,
                                               input logic [8:0] d,
                                               input logic [8:0] osz,
                                               input logic ac);
        logic [21:0] a;
        logic [NW-1:0] num;
        logic [DNW-1:0] den;
        logic zero;
        a = 22'(insz) * 22'({d, 1'b1});
        num = '0;
        den = 11'd1;
        zero = 1'b1;
        if (!ac) begin
            if (a > 22'(osz)) begin
                num  = NW'(a - 22'(osz)) << FRAC_W;
                den  = {1'b0, osz, 1'b0};
                zero = 1'b0;
            end
        end else if (osz > 9'd1) begin
            num  = NW'(22'(insz - 11'd1) * 22'(d)) << FRAC_W;
            den  = 11'(osz - 9'd1);
            zero = 1'b0;
        end
        return {zero, num, den};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            {r_zy, r_ny, r_dy} <= map_nd(w_ih, {1'b0, r_it.row}, r_oh, r_ac);
            {r_zx, r_nx, r_dx} <= map_nd(w_iw, {1'b0, r_it.col}, r_ow, r_ac);
        end
    end

    logic          r_dgo;
    logic [NW-1:0] w_qy, w_qx;
    logic          w_dny, w_dnx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dgo <= 1'b0;
        else          r_dgo <= i_cmd.div_go;
    end

    brp8_div #(.NW(NW), .DW(DNW)) u_divy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_dgo),
        .i_num(r_ny), .i_den(r_dy), .o_quo(w_qy), .o_done(w_dny)
    );
    brp8_div #(.NW(NW), .DW(DNW)) u_divx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_dgo),
        .i_num(r_nx), .i_den(r_dx), .o_quo(w_qx), .o_done(w_dnx)
    );
    assign o_sts.div_done = w_dny && w_dnx && !r_dgo;

    // Indices and fractions with edge handling.
    logic [NW-1:0] w_py, w_px;
    logic [10:0]   w_y0, w_x0, w_y1, w_x1;
    logic [FRAC_W-1:0] w_fy, w_fx;
    always_comb begin
        w_py = r_zy ? '0 : w_qy;
        w_px = r_zx ? '0 : w_qx;
        w_fy = w_py[FRAC_W-1:0];
        w_fx = w_px[FRAC_W-1:0];
        w_y0 = (w_py[NW-1:FRAC_W] > (NW-FRAC_W)'(w_ih - 11'd1)) ?
               (w_ih - 11'd1) : 11'(w_py[NW-1:FRAC_W]);
        w_x0 = (w_px[NW-1:FRAC_W] > (NW-FRAC_W)'(w_iw - 11'd1)) ?
               (w_iw - 11'd1) : 11'(w_px[NW-1:FRAC_W]);
        w_y1 = (w_y0 < w_ih - 11'd1) ? w_y0 + 11'd1 : w_y0;
        w_x1 = (w_x0 < w_iw - 11'd1) ? w_x0 + 11'd1 : w_x0;
    end

    // Image store, one port.
    logic [PXW-1:0] r_mem [DEP];
    logic [PXW-1:0] r_rd;
    logic [AW-1:0]  w_addr;
    logic [10:0]    w_ry, w_rx;
    always_comb begin
        w_ry = i_cmd.rd_sel[1] ? w_y1 : w_y0;
        w_rx = i_cmd.rd_sel[0] ? w_x1 : w_x0;
        if (i_cmd.wr_mem) begin
            w_addr = {PW'(r_it.plane), YW'(r_it.row), XW'(r_it.col)};
        end else begin
            w_addr = {PW'(r_it.plane), w_ry[YW-1:0], w_rx[XW-1:0]};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mem) begin
            r_mem[w_addr] <= {r_it.lane7, r_it.lane6, r_it.lane5, r_it.lane4,
                              r_it.lane3, r_it.lane2, r_it.lane1, r_it.lane0};
        end else if (i_cmd.rd_go) begin
            r_rd <= r_mem[w_addr];
        end
    end

    // Weight of each neighbour: product of two 17-bit weights.
    logic [16:0] w_h, w_w;
    logic [33:0] r_wgt;
    always_comb begin
        w_h = i_cmd.rd_sel[1] ? {1'b0, w_fy} : (17'h10000 - {1'b0, w_fy});
        w_w = i_cmd.rd_sel[0] ? {1'b0, w_fx} : (17'h10000 - {1'b0, w_fx});
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_go) r_wgt <= w_h * w_w;
    end

    // Per lane accumulation of weight times sample.
    logic signed [50:0] r_acc [8];
    logic signed [50:0] n_acc [8];
    logic signed [15:0] w_smp;
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_smp    = r_rd[k*LANE_W +: LANE_W];
            n_acc[k] = (i_cmd.acc_sel == 2'd0) ? 51'sd0 : r_acc[k];
            n_acc[k] = n_acc[k] + 51'($signed({1'b0, r_wgt})) * 51'(w_smp);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_go) begin
            for (int k = 0; k < 8; k++) r_acc[k] <= n_acc[k];
        end
    end

    // Round half up, saturate, register the result.
    function automatic logic [15:0] rnd(input logic signed [50:0] s);
        logic signed [50:0] t;
        logic signed [18:0] q;
        t = s + 51'sd2147483648;
        q = 19'(t >>> 32);
        if (q > 19'sd32767) return 16'h7FFF;
        if (q < -19'sd32768) return 16'h8000;
        return q[15:0];
    endfunction

    t_out_item r_res;
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (o_sts.coord_bad) begin
                r_res <= {1'b1, {(8*LANE_W){1'b0}}};
            end else begin
                r_res.coord_error <= 1'b0;
                r_res.out_lane0 <= rnd(r_acc[0]);
                r_res.out_lane1 <= rnd(r_acc[1]);
                r_res.out_lane2 <= rnd(r_acc[2]);
                r_res.out_lane3 <= rnd(r_acc[3]);
                r_res.out_lane4 <= rnd(r_acc[4]);
                r_res.out_lane5 <= rnd(r_acc[5]);
                r_res.out_lane6 <= rnd(r_acc[6]);
                r_res.out_lane7 <= rnd(r_acc[7]);
            end
        end
    end
    assign o_res = r_res;
endmodule

[src/bilinear_resize_packed8.sv]
// Top level: bilinear resize with a store of eight-lane pixels.
// A compute beat passes capture, decode, divider setup, the divider run, the four
// single-port store reads with their accumulation and a finish step; a write beat
// passes capture and decode only, an out-of-range compute capture, decode and finish.
// One item is in flight; a result held by the sink stalls only the next finish step.
// Synchronous active-low reset sets the registers to 64,64,64,64,0; the store is kept.
module bilinear_resize_packed8 #(
    parameter int unsigned MAX_IN_WIDTH  = brp8_pkg::MAX_IN_WIDTH_D,
    parameter int unsigned MAX_IN_HEIGHT = brp8_pkg::MAX_IN_HEIGHT_D,
    parameter int unsigned PLANES        = brp8_pkg::PLANES_D
) (
    input  logic i_clk,
    input  logic i_rst_n,
    brp8_item_if.sink   in_ch,
    brp8_item_if.source out_ch,
    brp8_cfg_if.sink    cfg
);
    import brp8_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    t_out_item w_res;

    assign cfg.ready = 1'b1;

    brp8_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    brp8_dp #(
        .MAX_IN_WIDTH(MAX_IN_WIDTH), .MAX_IN_HEIGHT(MAX_IN_HEIGHT),
        .PLANES(PLANES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg.valid), .i_cfg_idx(cfg.index), .i_cfg_dat(cfg.data),
        .i_item(t_in_item'(in_ch.data)), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_res(w_res)
    );

    assign out_ch.data = w_res;
endmodule

[src/brp8_checker.sv]
// Port-level checker for the bilinear resize block, bound to the top level.
module brp8_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [128:0] out_data
);
    // A result that waits keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // A write beat accepted while no result is waiting does not raise out_valid from its decode step.
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && !in_kind && !out_valid |=> ##1 !$rose(out_valid))
        else $error("write produced a result");

    // No new beat is taken in the cycle after one was accepted.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("two beats in flight");

    // An error result carries zero lanes.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data[128] |-> out_data[127:0] == '0)
        else $error("error result with non-zero lanes");
endmodule

bind bilinear_resize_packed8 brp8_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.data[146]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
